[sv/mhbp_pkg.sv]
// Shared types and constants of the message header byte parser.
package mhbp_pkg;

    // Payload counter width setting; the count saturates at 2^min(LEN_BITS,16) - 1.
    localparam int LEN_BITS = 16;
    localparam logic [15:0] PAY_LIMIT = (LEN_BITS >= 16) ? 16'hFFFF
                                       : 16'((32'd1 << LEN_BITS) - 32'd1);

    localparam int MIN_MSG_BYTES = 2;
    localparam logic [3:0] ID_STEPS_MAX = 4'd10;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_ROUTE   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ST_COMPRESSED = 3'd3;
    localparam logic [2:0] ST_OVERRUN    = 3'd4;
    localparam logic [2:0] ST_NO_BODY    = 3'd5;

    localparam logic [2:0] TYPE_REQUEST  = 3'd0;
    localparam logic [2:0] TYPE_NOTIFY   = 3'd1;
    localparam logic [2:0] TYPE_RESPONSE = 3'd2;
    localparam logic [2:0] TYPE_PUSH     = 3'd3;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_ID,
        PH_RLEN,
        PH_ROUTE,
        PH_PAYLOAD,
        PH_ERR
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [2:0]  msg_type;
        logic [63:0] msg_id;
        logic        route_compressed;
        logic [7:0]  route_length;
        logic [15:0] payload_length;
        logic [2:0]  status;
        logic        last_result;
    } t_result;

    // Results one accepted byte produces: a forwarded byte and/or a summary.
    typedef struct packed {
        logic    byte_vld;
        t_result byte_res;
        logic    sum_vld;
        t_result sum_res;
    } t_core_out;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

[sv/mhbp_in_if.sv]
// Input channel: one message byte per item with its end-of-message flag.
interface mhbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

[sv/mhbp_out_if.sv]
// Output channel: forwarded route/payload bytes and end-of-message summaries.
interface mhbp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [2:0]  msg_type;
    logic [63:0] msg_id;
    logic        route_compressed;
    logic [7:0]  route_length;
    logic [15:0] payload_length;
    logic [2:0]  status;
    logic        last_result;

    modport source (
        output valid, output kind, output byte_value, output msg_type, output msg_id,
        output route_compressed, output route_length, output payload_length,
        output status, output last_result, input ready
    );
    modport sink (
        input valid, input kind, input byte_value, input msg_type, input msg_id,
        input route_compressed, input route_length, input payload_length,
        input status, input last_result, output ready
    );
endinterface

[sv/message_header_byte_parser.sv]
// Message header byte parser: one byte of a message per input item, with the
// end-of-message flag on the last byte. Route and payload bytes come out as
// byte results as they arrive, and the last byte also yields a summary with
// type, id, route length, payload count and status. An accepted byte is held in
// the input register until the queue has room; then the parser state advances
// and its results enter a four-entry result queue, which drives the output. A
// new byte is accepted every cycle while the queue has room for two results; a
// byte that gives a forwarded byte and a summary puts two results in the queue,
// which hands out one at a time, so the output port sets the sustained rate on
// such bytes.
module message_header_byte_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhbp_in_if.sink     i_in,
    mhbp_out_if.source  o_out
);
    import mhbp_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       step;
    t_core_out  core_res;
    t_q_stat    q_stat;

    assign step       = r_in_vld && q_stat.room;
    assign i_in.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_message;
        end
    end

    mhbp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (core_res)
    );

    mhbp_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (core_res),
        .o_stat  (q_stat),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_sum_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> (core_res.sum_vld == r_in_last))
        else $error("summary not tied to the last byte of a message");

    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=> o_out.valid)
        else $error("no result pending after a message end");
`endif

endmodule

[sv/mhbp_core.sv]
// Parser state machine: decodes one byte per step and forms its results.
module mhbp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output mhbp_pkg::t_core_out   o_res
);
    import mhbp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_flags, n_flags;
    logic [63:0] r_id, n_id;
    logic [3:0]  r_id_step, n_id_step;
    logic [7:0]  r_rt_total, n_rt_total;
    logic [7:0]  r_rt_rem, n_rt_rem;
    logic [15:0] r_pay_cnt, n_pay_cnt;
    logic [2:0]  r_err, n_err;

    logic [2:0]  cur_type;
    logic [6:0]  id_shift;
    logic [63:0] id_part;
    logic [7:0]  rem_dec;
    logic        has_id;
    logic        routable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_flags    <= '0;
            r_id       <= '0;
            r_id_step  <= '0;
            r_rt_total <= '0;
            r_rt_rem   <= '0;
            r_pay_cnt  <= '0;
            r_err      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_id       <= n_id;
            r_id_step  <= n_id_step;
            r_rt_total <= n_rt_total;
            r_rt_rem   <= n_rt_rem;
            r_pay_cnt  <= n_pay_cnt;
            r_err      <= n_err;
        end
    end

    assign id_shift = 7'({3'd0, r_id_step} * 7'd7);
    assign id_part  = {57'd0, i_byte[6:0]} << id_shift;
    assign rem_dec  = r_rt_rem - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_id       = r_id;
        n_id_step  = r_id_step;
        n_rt_total = r_rt_total;
        n_rt_rem   = r_rt_rem;
        n_pay_cnt  = r_pay_cnt;
        n_err      = r_err;
        o_res      = '0;

        case (r_phase)
            PH_FLAG: begin
                n_flags    = i_byte[3:0];
                n_id       = '0;
                n_id_step  = '0;
                n_rt_total = '0;
                n_rt_rem   = '0;
                n_pay_cnt  = '0;
                n_err      = ST_OK;
                if (i_last) begin
                    n_err = ST_TOO_SHORT;
                end else if (i_byte[3]) begin
                    n_err   = ST_BAD_TYPE;
                    n_phase = PH_ERR;
                end else if (i_byte[3:1] == TYPE_REQUEST || i_byte[3:1] == TYPE_RESPONSE) begin
                    n_phase = PH_ID;
                end else if (i_byte[0]) begin
                    n_err   = ST_COMPRESSED;
                    n_phase = PH_ERR;
                end else begin
                    n_phase = PH_RLEN;
                end
            end
            PH_ID: begin
                // Bits of earlier groups lie below the shift, so OR adds them.
                if (r_id_step < ID_STEPS_MAX) begin
                    n_id      = r_id | id_part;
                    n_id_step = r_id_step + 4'd1;
                end
                if (i_last) begin
                    n_err = ST_NO_BODY;
                end else if (!i_byte[7]) begin
                    if (r_flags[3:1] == TYPE_RESPONSE) begin
                        n_phase = PH_PAYLOAD;
                    end else if (r_flags[0]) begin
                        n_err   = ST_COMPRESSED;
                        n_phase = PH_ERR;
                    end else begin
                        n_phase = PH_RLEN;
                    end
                end
            end
            PH_RLEN: begin
                n_rt_total = i_byte;
                n_rt_rem   = i_byte;
                if (i_last) begin
                    n_err = (i_byte != 8'd0) ? ST_OVERRUN : ST_OK;
                end else begin
                    n_phase = (i_byte != 8'd0) ? PH_ROUTE : PH_PAYLOAD;
                end
            end
            PH_ROUTE: begin
                o_res.byte_vld            = 1'b1;
                o_res.byte_res.kind       = KIND_ROUTE;
                o_res.byte_res.byte_value = i_byte;
                n_rt_rem = rem_dec;
                if (i_last) begin
                    n_err = (rem_dec != 8'd0) ? ST_OVERRUN : ST_OK;
                end else if (rem_dec == 8'd0) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res.byte_vld            = 1'b1;
                o_res.byte_res.kind       = KIND_PAYLOAD;
                o_res.byte_res.byte_value = i_byte;
                if (r_pay_cnt < PAY_LIMIT) begin
                    n_pay_cnt = r_pay_cnt + 16'd1;
                end
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        cur_type = n_flags[3:1];
        has_id   = (cur_type == TYPE_REQUEST) || (cur_type == TYPE_RESPONSE);
        routable = (cur_type == TYPE_REQUEST) || (cur_type == TYPE_NOTIFY)
                   || (cur_type == TYPE_PUSH);

        o_res.byte_res.last_result = !i_last;

        if (i_last) begin
            o_res.sum_vld                  = 1'b1;
            o_res.sum_res.kind             = KIND_SUMMARY;
            o_res.sum_res.msg_type         = cur_type;
            o_res.sum_res.msg_id           = has_id ? n_id : 64'd0;
            o_res.sum_res.route_compressed = routable & n_flags[0];
            o_res.sum_res.route_length     = n_rt_total;
            o_res.sum_res.payload_length   = n_pay_cnt;
            o_res.sum_res.status           = n_err;
            o_res.sum_res.last_result      = 1'b1;
            n_phase = PH_FLAG;
        end
    end

endmodule

[sv/mhbp_res_queue.sv]
// Small result queue that takes up to two results a cycle and hands out one.
module mhbp_res_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mhbp_pkg::t_core_out  i_res,
    output mhbp_pkg::t_q_stat    o_stat,
    mhbp_out_if.source           o_out
);
    import mhbp_pkg::*;

    t_result r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic        wr0, wr1;
    t_result     ent0;
    logic [QCNT_W-1:0] n_in;
    logic        pop;
    t_result     head;

    // The summary goes first when there is no forwarded byte.
    assign ent0 = i_res.byte_vld ? i_res.byte_res : i_res.sum_res;
    assign wr0  = i_push && (i_res.byte_vld || i_res.sum_vld);
    assign wr1  = i_push && i_res.byte_vld && i_res.sum_vld;
    assign n_in = QCNT_W'({1'b0, wr0}) + QCNT_W'({1'b0, wr1});
    assign pop  = o_out.valid && o_out.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(n_in);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + n_in - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_mem[r_wr_ptr] <= ent0;
        end
        if (wr1) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_res.sum_res;
        end
    end

    // Room for the worst case of two results from one byte.
    assign o_stat.room  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_stat.count = r_count;

    assign head = r_mem[r_rd_ptr];

    assign o_out.valid            = (r_count != '0);
    assign o_out.kind             = head.kind;
    assign o_out.byte_value       = head.byte_value;
    assign o_out.msg_type         = head.msg_type;
    assign o_out.msg_id           = head.msg_id;
    assign o_out.route_compressed = head.route_compressed;
    assign o_out.route_length     = head.route_length;
    assign o_out.payload_length   = head.payload_length;
    assign o_out.status           = head.status;
    assign o_out.last_result      = head.last_result;

endmodule
